/* rtl/salc_pkg.sv */
package salc_pkg;

	typedef enum logic [1:0] {
		REQ_IFETCH = 2'd0,
		REQ_LOAD   = 2'd1,
		REQ_STORE  = 2'd2,
		REQ_MODIFY = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		CFG_SET_BITS    = 2'd0,
		CFG_BLOCK_BITS  = 2'd1,
		CFG_WAYS_IN_USE = 2'd2
	} cfg_idx_t;

	localparam int CFG_DATA_W = 5;
	localparam int CFG_IDX_W  = 2;

	localparam logic [3:0] SET_BITS_RST    = 4'd4;
	localparam logic [4:0] BLOCK_BITS_RST  = 5'd4;
	localparam logic [2:0] WAYS_IN_USE_RST = 3'd4;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_UPDATE
	} back_state_t;

endpackage

/* rtl/salc_if.sv */
interface salc_req_if #(parameter int ADDR_WIDTH = 64);
	logic                  valid;
	logic                  ready;
	logic [1:0]            req_type;
	logic [ADDR_WIDTH-1:0] address;
	modport source (output valid, req_type, address, input ready);
	modport sink (input valid, req_type, address, output ready);
endinterface

interface salc_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  hits_added;
	logic        missed;
	logic        evicted;
	logic [31:0] hit_total;
	logic [31:0] miss_total;
	logic [31:0] eviction_total;
	modport source (output valid, hits_added, missed, evicted, hit_total, miss_total,
		eviction_total, input ready);
	modport sink (input valid, hits_added, missed, evicted, hit_total, miss_total,
		eviction_total, output ready);
endinterface

/* rtl/salc_front.sv */
module salc_front
	import salc_pkg::*;
#(
	parameter int MAX_SET_BITS = 10,
	parameter int ADDR_WIDTH = 64,
	parameter int TAG_W = ADDR_WIDTH - 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              in_type,
	input  logic [ADDR_WIDTH-1:0]   in_addr,
	input  logic [3:0]              set_bits,
	input  logic [4:0]              block_bits,
	output logic                    q_valid,
	input  logic                    q_ready,
	output logic [1:0]              q_type,
	output logic [MAX_SET_BITS-1:0] q_set,
	output logic [TAG_W-1:0]        q_tag
);
	localparam int DEPTH = 2;

	logic [1:0]              type_q [DEPTH];
	logic [MAX_SET_BITS-1:0] set_q  [DEPTH];
	logic [TAG_W-1:0]        tag_q  [DEPTH];
	logic                    wptr_q, rptr_q;
	logic [1:0]              cnt_q;
	logic [4:0]              sb;
	logic [MAX_SET_BITS-1:0] set_mask;
	logic [ADDR_WIDTH-1:0]   shifted;
	logic                    push, pop;

	always_comb begin
		sb = ({1'b0, set_bits} > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS) : {1'b0, set_bits};
		set_mask = MAX_SET_BITS'(({{MAX_SET_BITS{1'b0}}, 1'b1} << sb) - 1'b1);
		shifted = in_addr >> block_bits;
	end

	assign in_ready = (cnt_q != 2'(DEPTH));
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_type = type_q[rptr_q];
	assign q_set = set_q[rptr_q];
	assign q_tag = tag_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			type_q[wptr_q] <= in_type;
			set_q[wptr_q] <= MAX_SET_BITS'(shifted) & set_mask;
			tag_q[wptr_q] <= TAG_W'(shifted >> sb);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

/* rtl/salc_back.sv */
module salc_back
	import salc_pkg::*;
#(
	parameter int MAX_SET_BITS = 10,
	parameter int WAYS = 4,
	parameter int TAG_W = 62
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_valid,
	output logic                    q_ready,
	input  logic [1:0]              q_type,
	input  logic [MAX_SET_BITS-1:0] q_set,
	input  logic [TAG_W-1:0]        q_tag,
	input  logic [2:0]              ways_in_use,
	salc_rsp_if.source              rsp
);
	localparam int SETS = 1 << MAX_SET_BITS;
	localparam int AGE_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int WAY_W = $clog2(WAYS + 1);
	localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WAYS - 1);

	back_state_t state_q, state_d;

	logic [TAG_W-1:0] tag_mem [SETS][WAYS];
	logic [AGE_W-1:0] age_mem [SETS][WAYS];
	logic [WAYS-1:0]  vld_mem [SETS];
	logic [MAX_SET_BITS-1:0] clr_q;

	logic [TAG_W-1:0] rd_tag [WAYS];
	logic [AGE_W-1:0] rd_age_raw [WAYS];
	logic [WAYS-1:0]  rd_vld_raw;

	logic [1:0]              type_q;
	logic [MAX_SET_BITS-1:0] set_q;
	logic [TAG_W-1:0]        tag_q;

	logic [AGE_W-1:0] age [WAYS];
	logic [WAYS-1:0]  vld;
	logic [WAYS-1:0]  used;
	logic [WAY_W-1:0] nw;
	logic             hit, has_empty;
	logic [WAY_W-1:0] hit_w, empty_w, vic_w, tgt_w;
	logic [AGE_W-1:0] best, ref_age;
	logic             best_any;
	logic [AGE_W-1:0] new_age [WAYS];

	logic [1:0]  hits_q;
	logic        miss_q, ev_q;
	logic [31:0] hit_tot_q, miss_tot_q, ev_tot_q;
	logic        out_valid_q;
	logic        do_update;
	logic        take;
	logic        second_q;

	always_comb begin
		if (ways_in_use == 3'd0) nw = WAY_W'(1);
		else if (32'(ways_in_use) > WAYS) nw = WAY_W'(WAYS);
		else nw = WAY_W'(ways_in_use);
		for (int w = 0; w < WAYS; w++) begin
			used[w] = (w < 32'(nw));
			vld[w] = rd_vld_raw[w];
			age[w] = rd_age_raw[w];
		end
	end

	always_comb begin
		hit = 1'b0; hit_w = '0;
		has_empty = 1'b0; empty_w = '0;
		best_any = 1'b0; best = '0; vic_w = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (used[w] && vld[w]) begin
				if (!hit && rd_tag[w] == tag_q) begin
					hit = 1'b1;
					hit_w = WAY_W'(w);
				end
				if (!best_any || age[w] > best) begin
					best_any = 1'b1;
					best = age[w];
					vic_w = WAY_W'(w);
				end
			end else if (used[w] && !has_empty) begin
				has_empty = 1'b1;
				empty_w = WAY_W'(w);
			end
		end
		tgt_w = hit ? hit_w : (has_empty ? empty_w : vic_w);
		ref_age = hit ? age[hit_w[AGE_W-1:0]] : best;
		for (int w = 0; w < WAYS; w++) begin
			new_age[w] = age[w];
			if (used[w] && vld[w] && WAY_W'(w) != tgt_w &&
				((!hit && has_empty) || age[w] < ref_age) && age[w] < AGE_MAX)
				new_age[w] = age[w] + 1'b1;
			if (WAY_W'(w) == tgt_w) new_age[w] = '0;
		end
	end

	assign do_update = (state_q == ST_UPDATE);
	assign take = (state_q == ST_IDLE) && q_valid && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk) begin
		if (take) begin
			type_q <= q_type;
			set_q <= q_set;
			tag_q <= q_tag;
		end
		for (int w = 0; w < WAYS; w++) begin
			rd_tag[w] <= tag_mem[set_q][w];
			rd_age_raw[w] <= age_mem[set_q][w];
		end
		rd_vld_raw <= vld_mem[set_q];
		// clear one set per cycle after reset
		if (state_q == ST_CLEAR) vld_mem[clr_q] <= '0;
		if (do_update) begin
			for (int w = 0; w < WAYS; w++) begin
				if (used[w]) age_mem[set_q][w] <= new_age[w];
				else age_mem[set_q][w] <= age[w];
			end
			vld_mem[set_q] <= vld | (WAYS'(1) << tgt_w);
			if (!hit) tag_mem[set_q][tgt_w[AGE_W-1:0]] <= tag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			second_q <= 1'b0;
			out_valid_q <= 1'b0;
			hits_q <= '0; miss_q <= 1'b0; ev_q <= 1'b0;
			hit_tot_q <= '0; miss_tot_q <= '0; ev_tot_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (take && q_type == REQ_IFETCH) begin
				hits_q <= '0; miss_q <= 1'b0; ev_q <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (do_update && (type_q != REQ_MODIFY || second_q)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (do_update) begin
				if (hit) begin
					if (hit_tot_q != '1) hit_tot_q <= hit_tot_q + 1'b1;
				end else begin
					if (miss_tot_q != '1) miss_tot_q <= miss_tot_q + 1'b1;
					if (!has_empty && ev_tot_q != '1) ev_tot_q <= ev_tot_q + 1'b1;
				end
				// modify: second pass always hits
				if (!second_q) begin
					hits_q <= {1'b0, hit}; miss_q <= !hit; ev_q <= !hit && !has_empty;
				end else begin
					hits_q <= hits_q + 2'd1;
				end
				second_q <= (type_q == REQ_MODIFY) && !second_q;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		q_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == '1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (take) begin
					q_ready = 1'b1;
					if (q_type != REQ_IFETCH) state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_UPDATE;
			ST_UPDATE: state_d = (type_q == REQ_MODIFY && !second_q) ? ST_READ : ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign rsp.valid = out_valid_q;
	assign rsp.hits_added = hits_q;
	assign rsp.missed = miss_q;
	assign rsp.evicted = ev_q;
	assign rsp.hit_total = hit_tot_q;
	assign rsp.miss_total = miss_tot_q;
	assign rsp.eviction_total = ev_tot_q;
endmodule

/* rtl/set_assoc_lru_cache_tracker.sv */
// set-associative cache tracker with true lru replacement
// channels: req (req_type, address) in, rsp (hits_added, missed, evicted and
// saturating running totals) out, both valid/ready; config by a plain write
// port (cfg_we, cfg_idx, cfg_wdata), to be written by the user only while
// idle; the block itself does not enforce this
// each access word is split into set and tag in the front and queued two
// deep; the back takes a word (ST_IDLE), reads the set's tag store (ST_READ)
// and writes it back (ST_UPDATE); a modify reads and writes the same set a
// second time
// the result word of a load or store is made valid in the back's output
// register by its update, that of a modify by its second update
// an instruction fetch word produces its result word in the cycle after it is
// taken by the back, without touching state
// a result word waits in an output register while the receiver stalls; the
// back takes its next word in the cycle the result word leaves, and the
// front still takes up to two more words meanwhile
// after reset the back clears the line valid flags of all 2**MAX_SET_BITS sets
// (1024 by default), one set per cycle, before it takes a word; totals reset
// at once
module set_assoc_lru_cache_tracker
	import salc_pkg::*;
#(
	parameter int MAX_SET_BITS = 10,
	parameter int WAYS = 4,
	parameter int ADDR_WIDTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	salc_req_if.sink              req,
	salc_rsp_if.source            rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);
	localparam int TAG_W = ADDR_WIDTH - 2;

	logic [3:0] set_bits_q;
	logic [4:0] block_bits_q;
	logic [2:0] ways_in_use_q;

	logic                    qv, qr;
	logic [1:0]              qt;
	logic [MAX_SET_BITS-1:0] qs;
	logic [TAG_W-1:0]        qtag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q <= SET_BITS_RST;
			block_bits_q <= BLOCK_BITS_RST;
			ways_in_use_q <= WAYS_IN_USE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_SET_BITS: set_bits_q <= cfg_wdata[3:0];
				CFG_BLOCK_BITS: block_bits_q <= cfg_wdata;
				CFG_WAYS_IN_USE: ways_in_use_q <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	salc_front #(.MAX_SET_BITS(MAX_SET_BITS), .ADDR_WIDTH(ADDR_WIDTH), .TAG_W(TAG_W)) u_front (
		.clk, .arst_n,
		.in_valid(req.valid), .in_ready(req.ready),
		.in_type(req.req_type), .in_addr(req.address),
		.set_bits(set_bits_q), .block_bits(block_bits_q),
		.q_valid(qv), .q_ready(qr), .q_type(qt), .q_set(qs), .q_tag(qtag)
	);

	salc_back #(.MAX_SET_BITS(MAX_SET_BITS), .WAYS(WAYS), .TAG_W(TAG_W)) u_back (
		.clk, .arst_n,
		.q_valid(qv), .q_ready(qr), .q_type(qt), .q_set(qs), .q_tag(qtag),
		.ways_in_use(ways_in_use_q), .rsp(rsp)
	);
endmodule

/* dv/testbench.sv */
module testbench;
	import salc_pkg::*;

	localparam int MAX_SET_BITS = 10;
	localparam int WAYS = 4;
	localparam int ADDR_WIDTH = 64;
	localparam int LINES = (1 << MAX_SET_BITS) * WAYS;

	typedef struct {
		req_type_t   kind;
		logic [63:0] address;
	} access_t;

	typedef struct {
		logic [1:0]  hits_added;
		logic        missed;
		logic        evicted;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
		logic [31:0] eviction_total;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	salc_req_if #(.ADDR_WIDTH(ADDR_WIDTH)) req ();
	salc_rsp_if rsp ();

	set_assoc_lru_cache_tracker #(
		.MAX_SET_BITS(MAX_SET_BITS),
		.WAYS(WAYS),
		.ADDR_WIDTH(ADDR_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	// cache model
	logic [3:0]  m_set_bits = SET_BITS_RST;
	logic [4:0]  m_block_bits = BLOCK_BITS_RST;
	logic [2:0]  m_ways = WAYS_IN_USE_RST;
	logic        m_valid [LINES];
	logic [61:0] m_tag [LINES];
	logic [1:0]  m_age [LINES];
	logic [31:0] m_hits = '0;
	logic [31:0] m_misses = '0;
	logic [31:0] m_evictions = '0;

	access_t  pending_accesses[$];
	outcome_t expected_outcomes[$];
	int errors = 0;
	int words_sent = 0;
	int words_checked = 0;
	int send_idle = 0;
	int recv_idle = 0;

	function automatic logic [31:0] sat_inc(logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic bit cache_access(logic [63:0] a, inout bit ev);
		int sb, bb, nw, set, base, hit_w, empty_w, victim, best;
		logic [61:0] t;
		logic [1:0] r;
		sb = (m_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(m_set_bits);
		bb = int'(m_block_bits);
		nw = (m_ways == 0) ? 1 : ((m_ways > WAYS) ? WAYS : int'(m_ways));
		set = int'((a >> bb) & ((64'd1 << sb) - 64'd1));
		t = 62'(a >> (sb + bb));
		base = set * WAYS;
		hit_w = WAYS;
		empty_w = WAYS;
		victim = 0;
		best = -1;
		for (int w = 0; w < nw; w++) begin
			if (m_valid[base + w]) begin
				if (m_tag[base + w] == t && hit_w == WAYS) hit_w = w;
				if (int'(m_age[base + w]) > best) begin
					best = m_age[base + w];
					victim = w;
				end
			end else if (empty_w == WAYS) begin
				empty_w = w;
			end
		end
		if (hit_w != WAYS) begin
			r = m_age[base + hit_w];
			for (int w = 0; w < nw; w++)
				if (w != hit_w && m_valid[base + w] && m_age[base + w] < r &&
						m_age[base + w] < WAYS - 1)
					m_age[base + w]++;
			m_age[base + hit_w] = '0;
			return 1'b1;
		end
		if (empty_w != WAYS) begin
			for (int w = 0; w < nw; w++)
				if (m_valid[base + w] && m_age[base + w] < WAYS - 1) m_age[base + w]++;
			victim = empty_w;
		end else begin
			r = m_age[base + victim];
			for (int w = 0; w < nw; w++)
				if (w != victim && m_valid[base + w] && m_age[base + w] < r &&
						m_age[base + w] < WAYS - 1)
					m_age[base + w]++;
			ev = 1'b1;
		end
		m_valid[base + victim] = 1'b1;
		m_tag[base + victim] = t;
		m_age[base + victim] = '0;
		return 1'b0;
	endfunction

	function automatic outcome_t predict_outcome(access_t x);
		outcome_t o;
		bit ev, ev2;
		ev = 0;
		ev2 = 0;
		o.hits_added = 0;
		o.missed = 0;
		if (x.kind != REQ_IFETCH) begin
			if (cache_access(x.address, ev)) begin
				o.hits_added++;
				m_hits = sat_inc(m_hits);
			end else begin
				o.missed = 1;
				m_misses = sat_inc(m_misses);
				if (ev) m_evictions = sat_inc(m_evictions);
			end
			if (x.kind == REQ_MODIFY) begin
				void'(cache_access(x.address, ev2));
				o.hits_added++;
				m_hits = sat_inc(m_hits);
			end
		end
		o.evicted = ev;
		o.hit_total = m_hits;
		o.miss_total = m_misses;
		o.eviction_total = m_evictions;
		return o;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("mismatch word %0d %s: got %0h want %0h", words_checked, what, got, want);
	endtask

	initial begin
		for (int i = 0; i < LINES; i++) begin
			m_valid[i] = 0;
			m_tag[i] = '0;
			m_age[i] = '0;
		end
		forever #5 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		access_t x;
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.req_type <= '0;
			req.address <= '0;
		end else if (!req.valid || req.ready) begin
			if (pending_accesses.size() > 0 && $urandom_range(99) >= send_idle) begin
				x = pending_accesses.pop_front();
				expected_outcomes.push_back(predict_outcome(x));
				words_sent++;
				req.valid <= 1'b1;
				req.req_type <= x.kind;
				req.address <= x.address;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// receiver and monitor
	always @(posedge clk or negedge arst_n) begin
		outcome_t e;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= recv_idle);
			if (rsp.valid && rsp.ready) begin
				if (expected_outcomes.size() == 0) begin
					report("unexpected word", 0, 0);
				end else begin
					e = expected_outcomes.pop_front();
					if (rsp.hits_added !== e.hits_added)
						report("hits_added", rsp.hits_added, e.hits_added);
					if (rsp.missed !== e.missed) report("missed", rsp.missed, e.missed);
					if (rsp.evicted !== e.evicted) report("evicted", rsp.evicted, e.evicted);
					if (rsp.hit_total !== e.hit_total)
						report("hit_total", rsp.hit_total, e.hit_total);
					if (rsp.miss_total !== e.miss_total)
						report("miss_total", rsp.miss_total, e.miss_total);
					if (rsp.eviction_total !== e.eviction_total)
						report("eviction_total", rsp.eviction_total, e.eviction_total);
				end
				words_checked++;
			end
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_SET_BITS: m_set_bits = data[3:0];
			CFG_BLOCK_BITS: m_block_bits = data[4:0];
			default: m_ways = data[2:0];
		endcase
	endtask

	task automatic add_access(req_type_t k, logic [63:0] a);
		access_t x;
		x.kind = k;
		x.address = a;
		pending_accesses.push_back(x);
	endtask

	task automatic drain();
		while (pending_accesses.size() > 0 || req.valid || expected_outcomes.size() > 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// accesses mostly from a few tags and sets so that hits and evictions are common
	task automatic add_random(int n);
		logic [63:0] tags [8];
		logic [63:0] sets [3];
		logic [63:0] a;
		int sh, sb;
		req_type_t k;
		sb = (m_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(m_set_bits);
		sh = sb + int'(m_block_bits);
		foreach (tags[i]) tags[i] = {$urandom, $urandom};
		foreach (sets[i]) sets[i] = {$urandom, $urandom};
		for (int i = 0; i < n; i++) begin
			k = req_type_t'($urandom_range(3));
			if ($urandom_range(9) == 0) begin
				a = {$urandom, $urandom};
			end else begin
				a = (tags[$urandom_range(7)] << sh)
					| ((sets[$urandom_range(2)] << m_block_bits) & ((64'd1 << sh) - 64'd1))
					| ({$urandom, $urandom} & ((64'd1 << m_block_bits) - 64'd1));
			end
			add_access(k, a);
		end
	endtask

	initial begin
		int phase_set [9] = '{4, 0, 1, 10, 15, 0, 2, 3, 6};
		int phase_blk [9] = '{4, 0, 1, 16, 31, 1, 5, 6, 2};
		int phase_way [9] = '{4, 1, 2, 4, 7, 0, 3, 4, 5};
		cfg_we = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: every kind, address extremes, fill and evict one set, hits
		send_idle = 14;
		recv_idle = 74;
		add_access(REQ_IFETCH, 64'hFFFF_FFFF_FFFF_FFFF);
		add_access(REQ_LOAD, 64'h0);
		add_access(REQ_LOAD, 64'h0);
		add_access(REQ_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
		add_access(REQ_MODIFY, 64'hAAAA_AAAA_AAAA_AAAA);
		add_access(REQ_MODIFY, 64'h5555_5555_5555_5555);
		for (int i = 1; i <= 6; i++) add_access(REQ_LOAD, 64'(i) << 8);
		add_access(REQ_STORE, 64'h100);
		add_access(REQ_LOAD, 64'h0);
		add_access(REQ_IFETCH, 64'h0);
		add_access(REQ_MODIFY, 64'h700);
		drain();

		for (int p = 0; p < 9; p++) begin
			send_idle = (p < 3) ? 14 : ((p < 6) ? 74 : 0);
			recv_idle = (p < 3) ? 74 : ((p < 6) ? 14 : 0);
			write_reg(CFG_SET_BITS, CFG_DATA_W'(phase_set[p]));
			write_reg(CFG_BLOCK_BITS, CFG_DATA_W'(phase_blk[p]));
			write_reg(CFG_WAYS_IN_USE, CFG_DATA_W'(phase_way[p]));
			add_random(192);
			drain();
		end

		$display("checked %0d result words for %0d accesses over 9 cache geometries",
			words_checked, words_sent);
		$display("hits %0d misses %0d evictions %0d", m_hits, m_misses, m_evictions);
		if (errors == 0 && expected_outcomes.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout");
		$display("status: fail");
		$finish;
	end

endmodule
